// ----- hw/rtl/petts_pkg.sv -----
// ----------------------------------------------------------------------------
// petts_pkg: shared types and constants of the pose error to twist servo
// Holds the field widths, register indexes, datapath commands, the CORDIC
// arctangent table and the output saturation helper.
// ----------------------------------------------------------------------------
package petts_pkg;

  // Number of CORDIC vectoring steps (valid range 8 to 31).
  localparam int CORDIC_STEPS = 16;
  // Iterations of the bit-serial square root.
  localparam int SQRT_STEPS   = 32;
  // Quotient bits of the angular divider; the quotient always stays below 2^27.
  localparam int DIV_BITS     = 28;

  localparam int POS_W  = 32;
  localparam int QUAT_W = 16;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;
  localparam int OUT_W  = 32;
  localparam int MAG_W  = 41;

  // Register reset values.
  localparam logic [CFG_W-1:0] RST_LIN_GAIN  = 16'd384;
  localparam logic [CFG_W-1:0] RST_ANG_GAIN  = 16'd512;
  localparam logic [CFG_W-1:0] RST_LIN_DB    = 16'd66;
  localparam logic [CFG_W-1:0] RST_ANG_DB    = 16'd328;
  localparam logic [CFG_W-1:0] RST_STALE_LIM = 16'd200;

  typedef enum logic [IDX_W-1:0] {
    REG_LIN_GAIN  = 3'd0,
    REG_ANG_GAIN  = 3'd1,
    REG_LIN_DB    = 3'd2,
    REG_ANG_DB    = 3'd3,
    REG_STALE_LIM = 3'd4
  } cfg_reg_t;

  // Input item kinds.
  localparam logic KIND_TARGET = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LIN,
    OP_QMUL,
    OP_VSQ,
    OP_SQRT,
    OP_CORD_INIT,
    OP_CORD,
    OP_THETA,
    OP_AMUL1,
    OP_AMUL2,
    OP_DIV_INIT,
    OP_DIV,
    OP_ANG_OUT,
    OP_CONSUME,
    OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic go;
    logic n_zero;
    logic theta_low;
  } stat_t;

  typedef struct packed {
    logic                     kind;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic                     pose_valid;
    logic [TIME_W-1:0]        now_ms;
  } pose_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] lin_x;
    logic signed [OUT_W-1:0] lin_y;
    logic signed [OUT_W-1:0] lin_z;
    logic signed [OUT_W-1:0] ang_x;
    logic signed [OUT_W-1:0] ang_y;
    logic signed [OUT_W-1:0] ang_z;
    logic                    active;
  } twist_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   index;
    logic [CFG_W-1:0]   data;
  } cfg_wr_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'd843314857;
      5'd1:    r = 32'd497837829;
      5'd2:    r = 32'd263043837;
      5'd3:    r = 32'd133525159;
      5'd4:    r = 32'd67021687;
      5'd5:    r = 32'd33543516;
      5'd6:    r = 32'd16775851;
      5'd7:    r = 32'd8388437;
      5'd8:    r = 32'd4194283;
      5'd9:    r = 32'd2097149;
      5'd10:   r = 32'd1048576;
      5'd11:   r = 32'd524288;
      5'd12:   r = 32'd262144;
      5'd13:   r = 32'd131072;
      5'd14:   r = 32'd65536;
      5'd15:   r = 32'd32768;
      5'd16:   r = 32'd16384;
      5'd17:   r = 32'd8192;
      5'd18:   r = 32'd4096;
      5'd19:   r = 32'd2048;
      5'd20:   r = 32'd1024;
      5'd21:   r = 32'd512;
      5'd22:   r = 32'd256;
      5'd23:   r = 32'd128;
      5'd24:   r = 32'd64;
      5'd25:   r = 32'd32;
      5'd26:   r = 32'd16;
      5'd27:   r = 32'd8;
      5'd28:   r = 32'd4;
      5'd29:   r = 32'd2;
      5'd30:   r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Subtract mask of the quaternion product terms; bit k set means term k is negated.
  function automatic logic [3:0] qmul_neg(input logic [1:0] j);
    logic [3:0] r;
    case (j)
      2'd0:    r = 4'b0000;
      2'd1:    r = 4'b0110;
      2'd2:    r = 4'b1100;
      default: r = 4'b1010;
    endcase
    return r;
  endfunction

  // Sign and magnitude to a saturated 32-bit two's complement value.
  function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic [MAG_W-1:0] m);
    logic [OUT_W-1:0] r;
    if (neg) begin
      if (m >= 41'h0_8000_0000) r = 32'h8000_0000;
      else r = 32'(41'd0 - m);
    end else begin
      if (m > 41'h0_7FFF_FFFF) r = 32'h7FFF_FFFF;
      else r = m[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/petts_pose_if.sv -----
// ----------------------------------------------------------------------------
// petts_pose_if: input channel of the servo
// Carries one target pose or one control tick per request.
// ----------------------------------------------------------------------------
interface petts_pose_if;
  import petts_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic signed [QUAT_W-1:0] quat_w;
  logic signed [QUAT_W-1:0] quat_x;
  logic signed [QUAT_W-1:0] quat_y;
  logic signed [QUAT_W-1:0] quat_z;
  logic                     pose_valid;
  logic [TIME_W-1:0]        now_ms;

  modport source (output valid, kind, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y,
                  quat_z, pose_valid, now_ms, input ready);
  modport sink (input valid, kind, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y,
                quat_z, pose_valid, now_ms, output ready);
endinterface

// ----- hw/rtl/petts_twist_if.sv -----
// ----------------------------------------------------------------------------
// petts_twist_if: output channel of the servo
// Carries one twist request per control tick.
// ----------------------------------------------------------------------------
interface petts_twist_if;
  import petts_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] lin_x;
  logic signed [OUT_W-1:0] lin_y;
  logic signed [OUT_W-1:0] lin_z;
  logic signed [OUT_W-1:0] ang_x;
  logic signed [OUT_W-1:0] ang_y;
  logic signed [OUT_W-1:0] ang_z;
  logic                    active;

  modport source (output valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, active,
                  input ready);
  modport sink (input valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, active,
                output ready);
endinterface

// ----- hw/rtl/petts_cfg_if.sv -----
// ----------------------------------------------------------------------------
// petts_cfg_if: register write channel of the servo
// Carries one register index and its write data per request.
// ----------------------------------------------------------------------------
interface petts_cfg_if;
  import petts_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/pose_error_to_twist_servo.sv -----
// ----------------------------------------------------------------------------
// pose_error_to_twist_servo: Cartesian proportional servo on a quaternion error
// Stores a target pose and turns each control tick into a saturated twist.
// ----------------------------------------------------------------------------
// A target request (kind 0) is taken and gives no twist. A tick (kind 1)
// gives one twist. A tick without a fresh, unexpired target or with an
// invalid pose goes straight to the result. A computed tick runs the linear
// axes, the quaternion product, the squares, a one-bit-per-cycle square
// root, a CORDIC of CORDIC_STEPS steps, and then per rotation axis one
// multiply and a restoring divider; the angular path is skipped when the
// rotation is zero or below the angular deadband. Register writes are taken
// in any cycle; a finished twist waits in an output register while the next
// request is taken.
module pose_error_to_twist_servo (
  input logic          clk,
  input logic          rst,
  petts_pose_if.sink   pose,
  petts_twist_if.source twist,
  petts_cfg_if.sink    cfg
);
  import petts_pkg::*;

  pose_t   pose_p;
  twist_t  twist_p;
  cfg_wr_t cfg_wr;
  cmd_t    cmd;
  stat_t   stat;

  // Pack the channel payloads.
  assign pose_p = '{kind: pose.kind, pos_x: pose.pos_x, pos_y: pose.pos_y,
                    pos_z: pose.pos_z, quat_w: pose.quat_w, quat_x: pose.quat_x,
                    quat_y: pose.quat_y, quat_z: pose.quat_z,
                    pose_valid: pose.pose_valid, now_ms: pose.now_ms};
  assign cfg.ready = 1'b1;
  assign cfg_wr = '{en: cfg.valid, index: cfg.index, data: cfg.data};

  assign twist.lin_x = twist_p.lin_x;
  assign twist.lin_y = twist_p.lin_y;
  assign twist.lin_z = twist_p.lin_z;
  assign twist.ang_x = twist_p.ang_x;
  assign twist.ang_y = twist_p.ang_y;
  assign twist.ang_z = twist_p.ang_z;
  assign twist.active = twist_p.active;

  petts_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pose_valid  (pose.valid),
    .pose_ready  (pose.ready),
    .twist_valid (twist.valid),
    .twist_ready (twist.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  petts_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .pose   (pose_p),
    .cfg_wr (cfg_wr),
    .stat   (stat),
    .twist  (twist_p)
  );

endmodule

// ----- hw/rtl/petts_dp.sv -----
// ----------------------------------------------------------------------------
// petts_dp: datapath of the pose error to twist servo
// Holds the registers, the target store and all arithmetic units; each
// command from the controller performs one step.
// ----------------------------------------------------------------------------
module petts_dp (
  input  logic             clk,
  input  logic             rst,
  input  petts_pkg::cmd_t  cmd,
  input  petts_pkg::pose_t pose,
  input  petts_pkg::cfg_wr_t cfg_wr,
  output petts_pkg::stat_t stat,
  output petts_pkg::twist_t twist
);
  import petts_pkg::*;

  localparam int QC_W  = 34;
  localparam int VR_W  = 29;
  localparam int SQ_W  = 64;
  localparam int CX_W  = 40;
  localparam int CZ_W  = 36;
  localparam int TH_W  = 19;
  localparam int TG_W  = 35;
  localparam int DEN_W = 40;

  // Registers and state.
  logic [CFG_W-1:0]         lin_gain, ang_gain, lin_db, ang_db, stale_lim;
  logic signed [POS_W-1:0]  tgt_pos [3];
  logic signed [QUAT_W-1:0] tgt_q   [4];
  logic                     fresh;
  logic [TIME_W-1:0]        last_time;
  logic signed [POS_W-1:0]  cur_pos [3];
  logic signed [QUAT_W-1:0] cur_q   [4];
  logic [OUT_W-1:0]         res     [6];
  logic                     res_active;
  logic signed [QC_W-1:0]   qc      [4];
  logic [SQ_W-1:0]          acc, sq_v, sq_res, sq_one;
  logic signed [CX_W-1:0]   cx, cy;
  logic signed [CZ_W-1:0]   cz;
  logic [TH_W-1:0]          theta;
  logic [TG_W-1:0]          tg;
  logic [SQ_W-1:0]          num;
  logic [DEN_W-1:0]         rem;
  logic [DIV_BITS-1:0]      dq;

  // Combinational step values.
  logic [1:0]               ax;
  logic [TIME_W-1:0]        elapsed;
  logic signed [POS_W:0]    lin_e;
  logic [POS_W:0]           lin_m, lin_mz;
  logic [48:0]              lin_rnd;
  logic signed [QC_W-1:0]   qsum;
  logic [3:0]               qneg;
  logic signed [31:0]       qprod;
  logic [QC_W-1:0]          vmag, wmag;
  logic [VR_W-1:0]          vr, wr;
  logic [SQ_W-1:0]          acc_new, sq_trial;
  logic signed [CX_W-1:0]   xs, ys;
  logic signed [CZ_W-1:0]   atan_v;
  logic [32:0]              th_rnd;
  logic [DEN_W-1:0]         den, div_t;
  logic [SQ_W-1:0]          dividend;
  logic                     div_ge;

  assign ax = cmd.idx[1:0];

  // Freshness test of the target against the incoming tick.
  assign elapsed = pose.now_ms - last_time;
  assign stat.kind = pose.kind;
  assign stat.go = fresh && (elapsed <= {16'd0, stale_lim}) && pose.pose_valid;
  assign stat.n_zero = (sq_res == '0);
  assign stat.theta_low = (theta < {3'd0, ang_db});

  // Linear error, deadband, gain and rounding for the selected axis.
  always_comb begin
    lin_e = {tgt_pos[ax][POS_W-1], tgt_pos[ax]} - {cur_pos[ax][POS_W-1], cur_pos[ax]};
    lin_m = lin_e[POS_W] ? (33'd0 - lin_e) : lin_e;
    lin_mz = (lin_m < {17'd0, lin_db}) ? '0 : lin_m;
    lin_rnd = 49'(lin_mz) * 49'(lin_gain) + 49'd128;
  end

  // One quaternion product component: four independent products summed.
  always_comb begin
    qsum = '0;
    qneg = qmul_neg(ax);
    for (int k = 0; k < 4; k++) begin
      qprod = cur_q[k] * tgt_q[2'(k) ^ ax];
      if (qneg[k]) qsum = qsum - QC_W'(qprod);
      else qsum = qsum + QC_W'(qprod);
    end
  end

  // Truncated magnitudes of the error quaternion parts.
  always_comb begin
    vmag = qc[2'(ax + 2'd1)][QC_W-1] ? (34'd0 - qc[2'(ax + 2'd1)]) : qc[2'(ax + 2'd1)];
    wmag = qc[0][QC_W-1] ? (34'd0 - qc[0]) : qc[0];
    vr = VR_W'(vmag >> 4);
    wr = VR_W'(wmag >> 4);
    acc_new = ((ax == 2'd0) ? '0 : acc) + SQ_W'(58'(vr) * 58'(vr));
    sq_trial = sq_res + sq_one;
  end

  // CORDIC shifts and divider step.
  always_comb begin
    xs = cx >>> cmd.idx;
    ys = cy >>> cmd.idx;
    atan_v = CZ_W'(atan_q30(cmd.idx));
    th_rnd = (cz[CZ_W-1] ? 33'd0 : {cz[31:0], 1'b0}) + 33'd8192;
    den = {sq_res[31:0], 8'd0};
    dividend = num + SQ_W'(den >> 1);
    div_t = {rem[DEN_W-2:0], dq[DIV_BITS-1]};
    div_ge = (div_t >= den);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lin_gain <= RST_LIN_GAIN;
      ang_gain <= RST_ANG_GAIN;
      lin_db <= RST_LIN_DB;
      ang_db <= RST_ANG_DB;
      stale_lim <= RST_STALE_LIM;
    end else if (cfg_wr.en) begin
      case (cfg_reg_t'(cfg_wr.index))
        REG_LIN_GAIN:  lin_gain <= cfg_wr.data;
        REG_ANG_GAIN:  ang_gain <= cfg_wr.data;
        REG_LIN_DB:    lin_db <= cfg_wr.data;
        REG_ANG_DB:    ang_db <= cfg_wr.data;
        REG_STALE_LIM: stale_lim <= cfg_wr.data;
        default: begin
        end
      endcase
    end
  end

  // Target freshness and time stamp.
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= 1'b0;
      last_time <= '0;
    end else if (cmd.op == OP_ACCEPT && pose.kind == KIND_TARGET) begin
      fresh <= 1'b1;
      last_time <= pose.now_ms;
    end else if (cmd.op == OP_CONSUME) begin
      fresh <= 1'b0;
    end
  end

  // Datapath steps.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        if (pose.kind == KIND_TARGET) begin
          tgt_pos[0] <= pose.pos_x;
          tgt_pos[1] <= pose.pos_y;
          tgt_pos[2] <= pose.pos_z;
          tgt_q[0] <= pose.quat_w;
          tgt_q[1] <= pose.quat_x;
          tgt_q[2] <= pose.quat_y;
          tgt_q[3] <= pose.quat_z;
        end else begin
          cur_pos[0] <= pose.pos_x;
          cur_pos[1] <= pose.pos_y;
          cur_pos[2] <= pose.pos_z;
          cur_q[0] <= pose.quat_w;
          cur_q[1] <= pose.quat_x;
          cur_q[2] <= pose.quat_y;
          cur_q[3] <= pose.quat_z;
          for (int k = 0; k < 6; k++) res[k] <= '0;
          res_active <= 1'b0;
        end
      end
      OP_LIN: begin
        res[3'(ax)] <= sat_out(lin_e[POS_W], lin_rnd[48:8]);
      end
      OP_QMUL: begin
        qc[ax] <= qsum;
      end
      OP_VSQ: begin
        acc <= acc_new;
        sq_v <= acc_new;
        sq_res <= '0;
        sq_one <= SQ_W'(1) << 62;
      end
      OP_SQRT: begin
        if (sq_v >= sq_trial) begin
          sq_v <= sq_v - sq_trial;
          sq_res <= (sq_res >> 1) + sq_one;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_one <= sq_one >> 2;
      end
      OP_CORD_INIT: begin
        cx <= CX_W'(wr);
        cy <= CX_W'(sq_res);
        cz <= '0;
      end
      OP_CORD: begin
        if (cy > 0) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_v;
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_v;
        end
      end
      OP_THETA: begin
        theta <= th_rnd[32:14];
      end
      OP_AMUL1: begin
        tg <= TG_W'(theta) * TG_W'(ang_gain);
      end
      OP_AMUL2: begin
        num <= SQ_W'(tg) * SQ_W'(vr);
      end
      OP_DIV_INIT: begin
        rem <= DEN_W'(dividend >> DIV_BITS);
        dq <= dividend[DIV_BITS-1:0];
      end
      OP_DIV: begin
        rem <= div_ge ? (div_t - den) : div_t;
        dq <= {dq[DIV_BITS-2:0], div_ge};
      end
      OP_ANG_OUT: begin
        res[3'(ax) + 3'd3] <= sat_out(qc[2'(ax + 2'd1)][QC_W-1] ^ qc[0][QC_W-1],
                                      MAG_W'(dq));
      end
      OP_CONSUME: begin
        res_active <= 1'b1;
      end
      OP_OUT_LOAD: begin
        twist.lin_x <= res[0];
        twist.lin_y <= res[1];
        twist.lin_z <= res[2];
        twist.ang_x <= res[3];
        twist.ang_y <= res[4];
        twist.ang_z <= res[5];
        twist.active <= res_active;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/petts_ctrl.sv -----
// ----------------------------------------------------------------------------
// petts_ctrl: controller of the pose error to twist servo
// Sequences the datapath through the linear, quaternion, root, CORDIC and
// divider steps and runs both channel handshakes.
// ----------------------------------------------------------------------------
module petts_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             pose_valid,
  output logic             pose_ready,
  output logic             twist_valid,
  input  logic             twist_ready,
  input  petts_pkg::stat_t stat,
  output petts_pkg::cmd_t  cmd
);
  import petts_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_LIN     = 15'b000000000000010,
    S_QMUL    = 15'b000000000000100,
    S_VSQ     = 15'b000000000001000,
    S_SQRT    = 15'b000000000010000,
    S_CINIT   = 15'b000000000100000,
    S_CORD    = 15'b000000001000000,
    S_THETA   = 15'b000000010000000,
    S_AMUL1   = 15'b000000100000000,
    S_AMUL2   = 15'b000001000000000,
    S_DINIT   = 15'b000010000000000,
    S_DIV     = 15'b000100000000000,
    S_AOUT    = 15'b001000000000000,
    S_CONSUME = 15'b010000000000000,
    S_FINISH  = 15'b100000000000000
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] axis, axis_next;
  logic       out_valid, out_valid_next;

  assign pose_ready = (state == S_IDLE);
  assign twist_valid = out_valid;

  // Next state and datapath command.
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    axis_next = axis;
    out_valid_next = out_valid && !twist_ready;
    cmd.op = OP_NONE;
    cmd.idx = cnt;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (pose_valid) begin
          cmd.op = OP_ACCEPT;
          if (stat.kind == KIND_TICK) state_next = stat.go ? S_LIN : S_FINISH;
        end
      end
      S_LIN: begin
        cmd.op = OP_LIN;
        cnt_next = (cnt == 5'd2) ? '0 : cnt + 5'd1;
        if (cnt == 5'd2) state_next = S_QMUL;
      end
      S_QMUL: begin
        cmd.op = OP_QMUL;
        cnt_next = (cnt == 5'd3) ? '0 : cnt + 5'd1;
        if (cnt == 5'd3) state_next = S_VSQ;
      end
      S_VSQ: begin
        // The last square also loads the root unit.
        if (cnt == 5'd2) begin
          cmd.op = OP_VSQ;
          cnt_next = '0;
          state_next = S_SQRT;
        end else begin
          cmd.op = OP_VSQ;
          cnt_next = cnt + 5'd1;
        end
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(SQRT_STEPS - 1)) state_next = S_CINIT;
      end
      S_CINIT: begin
        cnt_next = '0;
        // A zero vector part means no rotation: skip the angular path.
        if (stat.n_zero) begin
          state_next = S_CONSUME;
        end else begin
          cmd.op = OP_CORD_INIT;
          state_next = S_CORD;
        end
      end
      S_CORD: begin
        cmd.op = OP_CORD;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(CORDIC_STEPS - 1)) state_next = S_THETA;
      end
      S_THETA: begin
        cmd.op = OP_THETA;
        state_next = S_AMUL1;
      end
      S_AMUL1: begin
        axis_next = '0;
        if (stat.theta_low) begin
          state_next = S_CONSUME;
        end else begin
          cmd.op = OP_AMUL1;
          state_next = S_AMUL2;
        end
      end
      S_AMUL2: begin
        cmd.op = OP_AMUL2;
        cmd.idx = {3'd0, axis};
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.op = OP_DIV_INIT;
        cnt_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(DIV_BITS - 1)) state_next = S_AOUT;
      end
      S_AOUT: begin
        cmd.op = OP_ANG_OUT;
        cmd.idx = {3'd0, axis};
        axis_next = axis + 2'd1;
        state_next = (axis == 2'd2) ? S_CONSUME : S_AMUL2;
      end
      S_CONSUME: begin
        cmd.op = OP_CONSUME;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // Hand the result to the output register once it is free.
        if (!out_valid || twist_ready) begin
          cmd.op = OP_OUT_LOAD;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      axis <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      axis <= axis_next;
      out_valid <= out_valid_next;
    end
  end

  // A tick that cannot use the target goes straight to the result.
  a_zero_tick: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && pose_valid && stat.kind == KIND_TICK && !stat.go)
    |=> state == S_FINISH)
    else $error("zero tick did not go to the result state");

  // A pending result blocks the next one.
  a_hold_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_valid && !twist_ready) |=> state == S_FINISH)
    else $error("result overwrote a pending twist");

  // Loading the output register always raises valid.
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT_LOAD) |=> out_valid)
    else $error("output load without valid");

  // The CORDIC counter stays within the step count.
  a_cord_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_CORD) |-> (cnt < 5'(CORDIC_STEPS)))
    else $error("CORDIC step counter out of range");

endmodule
